/* src/cbpg_pkg.sv */
package cbpg_pkg;

  // coordinate width default, handed down from the top level
  localparam int CoordBitsDefault = 12;

  // segment count register
  localparam int SegBits = 6;
  localparam logic [SegBits-1:0] SegCountReset = 6'd50;

  // curve parameter t: unsigned, 16 fraction bits, covers 0..1 inclusive
  localparam int TFracBits = 16;
  localparam int TBits     = TFracBits + 1;

  // serial divider of 2^16 by the segment count, one quotient bit a cycle
  localparam int DivSteps = TBits;

  // evaluation pipeline depth, output register included
  localparam int PipeDepth = 7;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;        // latch control points, clear divider and t
    logic div_step;    // one restoring division step
    logic div_first;   // first division step shifts in the leading one
    logic issue;       // launch the point at the current t
    logic issue_last;  // launched point is the one at t = 1
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic [SegBits-1:0] seg_n;      // effective segment count, never zero
    logic               advance;    // pipeline moves this cycle
    logic               last_done;  // final point of the curve taken downstream
  } status_t;

endpackage

/* src/cbpg_lane.sv */
module cbpg_lane #(
  parameter int COORD_BITS = cbpg_pkg::CoordBitsDefault
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic                             load,
  input  logic signed [COORD_BITS-1:0]     p0,
  input  logic signed [COORD_BITS-1:0]     p1,
  input  logic signed [COORD_BITS-1:0]     p2,
  input  logic signed [COORD_BITS-1:0]     p3,
  input  logic        [cbpg_pkg::TBits-1:0] t,
  output logic signed [COORD_BITS-1:0]     point
);
  import cbpg_pkg::*;

  // coefficient widths of the power basis a t^3 + b t^2 + c t + d
  localparam int EW  = COORD_BITS + 5;
  localparam int AW  = COORD_BITS + 3;
  localparam int BW  = COORD_BITS + 4;
  localparam int CW  = COORD_BITS + 3;
  // horner partial results, each with 16 more fraction bits than the last
  localparam int HiW = COORD_BITS + 5;
  localparam int H1W = HiW + TFracBits;
  localparam int H2W = HiW + 2 * TFracBits;
  localparam int H3W = HiW + 3 * TFracBits;
  localparam int M1W = AW + TBits + 1;
  localparam int PHW = HiW + TBits + 1;
  localparam int PLW = TFracBits + TBits;

  logic signed [EW-1:0]  e0, e1, e2, e3;
  logic signed [EW-1:0]  a_full, b_full, c_full;

  logic signed [AW-1:0]  coef_a;
  logic signed [BW-1:0]  coef_b;
  logic signed [CW-1:0]  coef_c;
  logic signed [COORD_BITS-1:0] coef_d;

  logic signed [M1W-1:0] m1;
  logic signed [H1W-1:0] h1;
  logic signed [PHW-1:0] ph;
  logic        [PLW-1:0] pl;
  logic signed [H2W-1:0] h2;
  logic signed [PHW-1:0] qhi;
  logic        [PLW-1:0] qmid;
  logic        [PLW-1:0] qlo;
  logic signed [H3W-1:0] s3;

  logic [TBits-1:0] t1, t2, t3, t4;

  logic signed [TBits:0]  ts0, ts2, ts4;
  logic signed [HiW-1:0]  h1_hi;
  logic        [TFracBits-1:0] h1_lo;
  logic signed [HiW-1:0]  h2_hi;
  logic        [TFracBits-1:0] h2_mid, h2_lo;
  logic signed [H1W-1:0]  h1_next;
  logic signed [H2W-1:0]  h2_next;
  logic signed [H3W-1:0]  s3_next;
  logic signed [H3W-1:0]  v3;

  // power basis coefficients from the control points
  always_comb begin
    e0 = EW'(p0);
    e1 = EW'(p1);
    e2 = EW'(p2);
    e3 = EW'(p3);
    a_full = e3 - e0 + (e1 <<< 1) + e1 - (e2 <<< 1) - e2;
    b_full = (e0 <<< 1) + e0 - (e1 <<< 2) - (e1 <<< 1) + (e2 <<< 1) + e2;
    c_full = (e1 <<< 1) + e1 - (e0 <<< 1) - e0;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      coef_a <= AW'(a_full);
      coef_b <= BW'(b_full);
      coef_c <= CW'(c_full);
      coef_d <= p0;
    end
  end

  // horner steps, multiplies split at 16-bit boundaries of the wide operand
  always_comb begin
    ts0    = $signed({1'b0, t});
    ts2    = $signed({1'b0, t2});
    ts4    = $signed({1'b0, t4});
    h1_hi  = h1[H1W-1:TFracBits];
    h1_lo  = h1[TFracBits-1:0];
    h2_hi  = h2[H2W-1:2*TFracBits];
    h2_mid = h2[2*TFracBits-1:TFracBits];
    h2_lo  = h2[TFracBits-1:0];
    h1_next = H1W'(m1) + (H1W'(coef_b) <<< TFracBits);
    h2_next = (H2W'(ph) <<< TFracBits) + H2W'($signed({1'b0, pl}))
            + (H2W'(coef_c) <<< (2 * TFracBits));
    s3_next = (H3W'(qhi) <<< (2 * TFracBits))
            + (H3W'($signed({1'b0, qmid})) <<< TFracBits)
            + H3W'($signed({1'b0, qlo}));
    // add d, then half an lsb, then floor
    v3 = s3 + (H3W'(coef_d) <<< (3 * TFracBits))
       + (H3W'(1) <<< (3 * TFracBits - 1));
  end

  // pipeline registers, advanced together
  always_ff @(posedge clk) begin
    if (en) begin
      m1    <= coef_a * ts0;
      t1    <= t;
      h1    <= h1_next;
      t2    <= t1;
      ph    <= h1_hi * ts2;
      pl    <= h1_lo * t2;
      t3    <= t2;
      h2    <= h2_next;
      t4    <= t3;
      qhi   <= h2_hi * ts4;
      qmid  <= h2_mid * t4;
      qlo   <= h2_lo * t4;
      s3    <= s3_next;
      point <= v3[3*TFracBits +: COORD_BITS];
    end
  end

endmodule

/* src/cbpg_datapath.sv */
module cbpg_datapath #(
  parameter int COORD_BITS = cbpg_pkg::CoordBitsDefault,
  parameter int IN_W       = ((8 * COORD_BITS + 7) / 8) * 8,
  parameter int OUT_W      = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  cbpg_pkg::cmd_t                 cmd,
  output cbpg_pkg::status_t              status,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cbpg_pkg::SegBits-1:0]   cfg_data,
  input  logic [IN_W-1:0]                s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [OUT_W-1:0]               m_tdata,
  output logic                           m_tlast
);
  import cbpg_pkg::*;

  logic [SegBits-1:0]   seg_count;
  logic [SegBits-1:0]   seg_n;
  logic [TBits-1:0]     step_q;
  logic [SegBits-1:0]   step_r;
  logic [SegBits:0]     div_shift;
  logic                 div_bit;
  logic [TBits-1:0]     t;
  logic [SegBits-1:0]   t_rem;
  logic [SegBits:0]     rem_sum;
  logic                 rem_wrap;
  logic [PipeDepth-1:0] vld;
  logic [PipeDepth-1:0] lst;
  logic                 advance;
  logic signed [COORD_BITS-1:0] pt [2];

  // segment count register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_count <= SegCountReset;
    end else if (cfg_valid) begin
      seg_count <= cfg_data;
    end
  end

  // zero segments behaves as one
  assign seg_n = (seg_count == '0) ? SegBits'(1) : seg_count;

  // restoring division of 2^16 by n gives the t step q and remainder r
  always_comb begin
    div_shift = {step_r, cmd.div_first};
    div_bit   = (div_shift >= {1'b0, seg_n});
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      step_q <= '0;
      step_r <= '0;
    end else if (cmd.div_step) begin
      step_q <= {step_q[TBits-2:0], div_bit};
      step_r <= div_bit ? SegBits'(div_shift - {1'b0, seg_n}) : div_shift[SegBits-1:0];
    end
  end

  // t = floor(k * 2^16 / n), stepped by q with the remainder carried along
  always_comb begin
    rem_sum  = {1'b0, t_rem} + {1'b0, step_r};
    rem_wrap = (rem_sum >= {1'b0, seg_n});
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t     <= '0;
      t_rem <= '0;
    end else if (cmd.issue) begin
      t     <= t + step_q + TBits'(rem_wrap);
      t_rem <= rem_wrap ? SegBits'(rem_sum - {1'b0, seg_n}) : rem_sum[SegBits-1:0];
    end
  end

  // pipeline moves unless the output register is held
  assign advance = !vld[PipeDepth-1] || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[PipeDepth-2:0], cmd.issue};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      lst <= {lst[PipeDepth-2:0], cmd.issue_last};
    end
  end

  // one evaluation lane for x, one for y
  for (genvar i = 0; i < 2; i++) begin : g_lane
    cbpg_lane #(
      .COORD_BITS(COORD_BITS)
    ) u_lane (
      .clk   (clk),
      .en    (advance),
      .load  (cmd.load),
      .p0    ($signed(s_tdata[(0 + i) * COORD_BITS +: COORD_BITS])),
      .p1    ($signed(s_tdata[(2 + i) * COORD_BITS +: COORD_BITS])),
      .p2    ($signed(s_tdata[(4 + i) * COORD_BITS +: COORD_BITS])),
      .p3    ($signed(s_tdata[(6 + i) * COORD_BITS +: COORD_BITS])),
      .t     (t),
      .point (pt[i])
    );
  end

  // output register is the last pipeline stage
  assign m_tvalid = vld[PipeDepth-1];
  assign m_tlast  = lst[PipeDepth-1];
  assign m_tdata  = OUT_W'({pt[1], pt[0]});

  always_comb begin
    status.seg_n     = seg_n;
    status.advance   = advance;
    status.last_done = vld[PipeDepth-1] && lst[PipeDepth-1] && m_tready;
  end

endmodule

/* src/cbpg_ctrl.sv */
module cbpg_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output cbpg_pkg::cmd_t    cmd,
  input  cbpg_pkg::status_t status
);
  import cbpg_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_DIV   = 4'b0010,
    ST_RUN   = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_t;

  state_t             state, state_next;
  logic [SegBits-1:0] cnt, cnt_next;

  // next state and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step  = 1'b1;
        cmd.div_first = (cnt == '0);
        if (cnt == SegBits'(DivSteps - 1)) begin
          cnt_next   = '0;
          state_next = ST_RUN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_RUN: begin
        if (status.advance) begin
          cmd.issue      = 1'b1;
          cmd.issue_last = (cnt == status.seg_n);
          if (cnt == status.seg_n) begin
            state_next = ST_DRAIN;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        if (status.last_done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

/* src/cubic_bezier_point_generator_core.sv */
// channel   direction  payload (lowest bits first)
// s_axis    in         tdata: ctrl_x0 ctrl_y0 ctrl_x1 ctrl_y1 ctrl_x2 ctrl_y2 ctrl_x3 ctrl_y3
// m_axis    out        tdata: point_x point_y, zero pad; tlast: last_point
// cfg       in         cfg_data: segment_count, always ready
//
// for one item the core accepts it, runs the serial divider that forms the t
// step, launches N + 1 points at one a cycle while the pipeline advances, and
// drains the last point through the evaluation pipeline.
// synchronous active-high reset; segment_count resets to 50.
// a held output stalls the whole evaluation pipeline; no new item is taken
// until the last point of the current curve has left.
module cubic_bezier_point_generator_core #(
  parameter int COORD_BITS = cbpg_pkg::CoordBitsDefault
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // ctrl_x0, ctrl_y0, ctrl_x1, ctrl_y1, ctrl_x2, ctrl_y2, ctrl_x3, ctrl_y3
  input  logic [((8*COORD_BITS+7)/8)*8-1:0]     s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // point_x, point_y, zero pad
  output logic [((2*COORD_BITS+7)/8)*8-1:0]     m_tdata,
  output logic                                  m_tlast,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [cbpg_pkg::SegBits-1:0]          cfg_data
);
  import cbpg_pkg::*;

  localparam int InW  = ((8 * COORD_BITS + 7) / 8) * 8;
  localparam int OutW = ((2 * COORD_BITS + 7) / 8) * 8;

  cmd_t    cmd;
  status_t status;

  // sequencer
  cbpg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .status   (status)
  );

  // t generation and point evaluation
  cbpg_datapath #(
    .COORD_BITS(COORD_BITS),
    .IN_W      (InW),
    .OUT_W     (OutW)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule
